// ----- rtl/core/ovl_pkg.sv -----
// Package for the ordered value list: operation codes and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package ovl_pkg;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_DUMP   = 2'd3
    } opcode_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input beat
        logic lookup;     // register compare vector
        logic commit;     // apply op, emit single result
        logic dump_step;  // emit head entry, rotate list
    } ovl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        opcode_t op;
        logic    empty;
        logic    slot_free;
        logic    dump_final;
    } ovl_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/ovl_ctrl.sv -----
// Controller FSM for the ordered value list.
// Depends on ovl_pkg (command/status structs, opcodes).
`default_nettype none

module ovl_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  ovl_pkg::ovl_status_t    status,
    output ovl_pkg::ovl_cmd_t       cmd
);
    import ovl_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_COMMIT,
        ST_DUMP
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                if (status.op == OP_DUMP && !status.empty)
                    state_next = ST_DUMP;
                else
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (status.slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DUMP:
            begin
                if (status.slot_free)
                begin
                    cmd.dump_step = 1'b1;
                    if (status.dump_final)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/ovl_datapath.sv -----
// Datapath for the ordered value list: cell chain, entry count,
// match vector, dump index and output register. Depends on ovl_pkg.
`default_nettype none

module ovl_datapath
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [1:0]         in_op,
    input  wire logic signed [31:0] in_value,
    input  ovl_pkg::ovl_cmd_t       cmd,
    output ovl_pkg::ovl_status_t    status,
    input  wire logic               out_ready,
    output logic                    out_valid,
    output logic [1:0]              out_op,
    output logic signed [31:0]      out_value,
    output logic                    out_has,
    output logic                    out_found,
    output logic                    out_dropped,
    output logic [4:0]              out_count,
    output logic                    out_last
);
    import ovl_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    logic signed [31:0] cell_reg [CAPACITY];
    logic [CW-1:0]      count_reg;
    opcode_t            op_reg;
    logic [31:0]        val_reg;
    logic [CAPACITY-1:0] match_reg;
    logic [IW-1:0]      dump_idx_reg;

    logic [CAPACITY-1:0] match_now;
    logic [CAPACITY-1:0] shift_mask;
    logic                hit;
    logic                full;
    logic [CW-1:0]       count_after;

    // cells at or above the first match close the gap: x | -x
    assign shift_mask = match_reg | ((~match_reg) + {{(CAPACITY-1){1'b0}}, 1'b1});
    assign hit        = |match_reg;
    assign full       = (count_reg == CW'(CAPACITY));

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
            match_now[i] = (CW'(i) < count_reg) && (cell_reg[i] == val_reg);
    end

    always_comb
    begin
        count_after = count_reg;
        case (op_reg)
            OP_APPEND: if (!full) count_after = count_reg + CW'(1);
            OP_REMOVE: if (hit)   count_after = count_reg - CW'(1);
            default:   count_after = count_reg;
        endcase
    end

    assign status.op         = op_reg;
    assign status.empty      = (count_reg == '0);
    assign status.slot_free  = !out_valid || out_ready;
    assign status.dump_final = (CW'(dump_idx_reg) == count_reg - CW'(1));

    // item capture, lookup, dump index
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= opcode_t'(in_op);
            val_reg      <= in_value;
            dump_idx_reg <= '0;
        end
        if (cmd.lookup)
            match_reg <= match_now;
        if (cmd.dump_step)
            dump_idx_reg <= dump_idx_reg + IW'(1);
    end

    // cell chain
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (cmd.commit && op_reg == OP_APPEND && !full && CW'(i) == count_reg)
                cell_reg[i] <= val_reg;
            else if (cmd.commit && op_reg == OP_REMOVE && shift_mask[i]
                     && i < CAPACITY - 1)
                cell_reg[i] <= cell_reg[(i + 1) % CAPACITY];
            else if (cmd.dump_step)
            begin
                // rotate the occupied part by one
                if (CW'(i + 1) < count_reg)
                    cell_reg[i] <= cell_reg[(i + 1) % CAPACITY];
                else if (CW'(i + 1) == count_reg)
                    cell_reg[i] <= cell_reg[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.commit)
            count_reg <= count_after;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (cmd.commit || cmd.dump_step)
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_op      <= op_reg;
            out_value   <= '0;
            out_has     <= 1'b0;
            out_found   <= (op_reg == OP_REMOVE || op_reg == OP_SEARCH) && hit;
            out_dropped <= (op_reg == OP_APPEND) && full;
            out_count   <= 5'(count_after);
            out_last    <= 1'b1;
        end
        else if (cmd.dump_step)
        begin
            out_op      <= op_reg;
            out_value   <= cell_reg[0];
            out_has     <= 1'b1;
            out_found   <= 1'b0;
            out_dropped <= 1'b0;
            out_count   <= 5'(count_reg);
            out_last    <= status.dump_final;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ordered_value_list.sv -----
// Ordered value list: an insertion-ordered list of signed 32-bit values in
// a chain of registers, with append, remove-first-match, search and dump.
//
// Use:
//   Slave stream: tuser = opcode, tdata = item_value. One item in flight;
//   tready is high only while the block is idle.
//   Master stream: one result beat per append, remove or search and per
//   empty dump; one beat per entry for a non-empty dump, oldest first, with
//   tlast on the final beat of each item's run.
// Sequence:
//   Append, remove, search: accept captures the item, the lookup stage
//   registers the compare vector of all cells, commit applies the op.
//   The next item is accepted only when the block is idle again.
//   Dump of N entries: lookup, then one beat per cycle while not stalled;
//   the chain rotates by one cell per beat and is back in order at the end.
// Reset: count clears to zero; list contents are undefined and never read
//   beyond the count. No clearing pass.
// Stall: the output register holds its beat while m_axis_tready is low; the
//   block accepts the next item meanwhile but commits nothing until the
//   output slot frees. Dumps simply pause.
`default_nettype none

module ordered_value_list
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] item_value
    input  wire logic [7:0]  s_axis_tuser,   // [1:0] opcode, [7:2] zero

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [31:0] out_value, [32] found,
                                             // [33] dropped, [38:34] entry_count,
                                             // [39] zero
    output logic [7:0]       m_axis_tuser,   // [1:0] op_echo, [2] has_value,
                                             // [7:3] zero
    output logic             m_axis_tlast
);
    import ovl_pkg::*;

    ovl_cmd_t           cmd;
    ovl_status_t        status;

    logic [1:0]         out_op;
    logic signed [31:0] out_value;
    logic               out_has;
    logic               out_found;
    logic               out_dropped;
    logic [4:0]         out_count;

    ovl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ovl_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_op       (s_axis_tuser[1:0]),
        .in_value    (s_axis_tdata),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_op      (out_op),
        .out_value   (out_value),
        .out_has     (out_has),
        .out_found   (out_found),
        .out_dropped (out_dropped),
        .out_count   (out_count),
        .out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_count, out_dropped, out_found, out_value};
    assign m_axis_tuser = {5'b0, out_has, out_op};

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for ordered_value_list: a directed table, then random
// op streams under four handshake pressure phases, all checked beat by beat.
// Depends on ovl_pkg (opcode_t) and the ordered_value_list RTL.

module tb_top;

    import ovl_pkg::*;

    localparam int LIST_DEPTH = 16;
    localparam int RAND_PER_PHASE = 36;   // four phases, ~180 items with the table
    localparam int WATCHDOG_LIMIT = 4000; // cycles with no beat on either side
    localparam int MAX_REPORTS = 40;

    // per phase: no idling, slow sender, slow receiver, both slow
    localparam int SRC_IDLE_PCT [4] = '{0, 88, 0, 23};
    localparam int SNK_STALL_PCT [4] = '{0, 0, 88, 23};

    // one result beat, with the fields the scoreboard takes from the output stream
    typedef struct packed {
        opcode_t     op;
        logic [31:0] value;
        logic        has_value;
        logic        found;
        logic        dropped;
        logic [4:0]  count;
        logic        last;
    } list_result_t;

    // one row of the directed table; reps > 1 appends val, val+1, ...
    typedef struct packed {
        opcode_t      op;
        logic [31:0]  val;
        logic [4:0]   reps;
        logic         typed_want;   // compare against want instead of predictor
        list_result_t want;
    } stim_row_t;

    localparam stim_row_t DIR_ROWS [23] = '{
        // reset state: empty dump, search and remove on an empty list
        '{OP_DUMP,   32'h0000_0000, 5'd1, 1'b1, '{OP_DUMP,   32'h0, 1'b0, 1'b0, 1'b0, 5'd0, 1'b1}},
        '{OP_SEARCH, 32'h0000_0000, 5'd1, 1'b1, '{OP_SEARCH, 32'h0, 1'b0, 1'b0, 1'b0, 5'd0, 1'b1}},
        '{OP_REMOVE, 32'h0000_0000, 5'd1, 1'b1, '{OP_REMOVE, 32'h0, 1'b0, 1'b0, 1'b0, 5'd0, 1'b1}},
        // value extremes
        '{OP_APPEND, 32'h8000_0000, 5'd1, 1'b1, '{OP_APPEND, 32'h0, 1'b0, 1'b0, 1'b0, 5'd1, 1'b1}},
        '{OP_APPEND, 32'h7FFF_FFFF, 5'd1, 1'b1, '{OP_APPEND, 32'h0, 1'b0, 1'b0, 1'b0, 5'd2, 1'b1}},
        '{OP_APPEND, 32'h0000_0000, 5'd1, 1'b1, '{OP_APPEND, 32'h0, 1'b0, 1'b0, 1'b0, 5'd3, 1'b1}},
        '{OP_APPEND, 32'hFFFF_FFFF, 5'd1, 1'b1, '{OP_APPEND, 32'h0, 1'b0, 1'b0, 1'b0, 5'd4, 1'b1}},
        '{OP_SEARCH, 32'h8000_0000, 5'd1, 1'b1, '{OP_SEARCH, 32'h0, 1'b0, 1'b1, 1'b0, 5'd4, 1'b1}},
        // one bit off a stored value must miss: full 32-bit compare
        '{OP_SEARCH, 32'h7FFF_FFFE, 5'd1, 1'b1, '{OP_SEARCH, 32'h0, 1'b0, 1'b0, 1'b0, 5'd4, 1'b1}},
        '{OP_SEARCH, 32'hFFFF_FFFF, 5'd1, 1'b1, '{OP_SEARCH, 32'h0, 1'b0, 1'b1, 1'b0, 5'd4, 1'b1}},
        '{OP_DUMP,   32'h0000_0000, 5'd1, 1'b0, '0},
        // remove from the middle, then the same value again (absent)
        '{OP_REMOVE, 32'h7FFF_FFFF, 5'd1, 1'b1, '{OP_REMOVE, 32'h0, 1'b0, 1'b1, 1'b0, 5'd3, 1'b1}},
        '{OP_REMOVE, 32'h7FFF_FFFF, 5'd1, 1'b1, '{OP_REMOVE, 32'h0, 1'b0, 1'b0, 1'b0, 5'd3, 1'b1}},
        // duplicate at the tail; remove must take the older copy
        '{OP_APPEND, 32'h8000_0000, 5'd1, 1'b1, '{OP_APPEND, 32'h0, 1'b0, 1'b0, 1'b0, 5'd4, 1'b1}},
        '{OP_REMOVE, 32'h8000_0000, 5'd1, 1'b1, '{OP_REMOVE, 32'h0, 1'b0, 1'b1, 1'b0, 5'd3, 1'b1}},
        // dump ignores its value field
        '{OP_DUMP,   32'hFFFF_FFFF, 5'd1, 1'b0, '0},
        // fill to capacity, then an append that must be dropped
        '{OP_APPEND, 32'h0001_0000, 5'd13, 1'b0, '0},
        '{OP_APPEND, 32'h5A5A_5A5A, 5'd1, 1'b1, '{OP_APPEND, 32'h0, 1'b0, 1'b0, 1'b1, 5'd16, 1'b1}},
        '{OP_DUMP,   32'h0000_0000, 5'd1, 1'b0, '0},
        // remove the tail entry, then the head entry
        '{OP_REMOVE, 32'h0001_000C, 5'd1, 1'b1, '{OP_REMOVE, 32'h0, 1'b0, 1'b1, 1'b0, 5'd15, 1'b1}},
        '{OP_REMOVE, 32'h0000_0000, 5'd1, 1'b1, '{OP_REMOVE, 32'h0, 1'b0, 1'b1, 1'b0, 5'd14, 1'b1}},
        '{OP_SEARCH, 32'h8000_0000, 5'd1, 1'b1, '{OP_SEARCH, 32'h0, 1'b0, 1'b1, 1'b0, 5'd14, 1'b1}},
        '{OP_DUMP,   32'h0000_0000, 5'd1, 1'b0, '0}
    };

    // values that recur often enough to give search and remove real hits
    localparam logic [31:0] VALUE_POOL [8] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
        32'h7FFF_FFFF, 32'h5555_AAAA, 32'hAAAA_5555, 32'h1234_5678
    };

    // DUT ports; the bench drives the DUT inputs to known values from time zero
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [7:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [7:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // predictor state and scoreboard
    logic [31:0]  held_values [$];     // shadow of the list, oldest first
    list_result_t step_beats [$];      // beats predicted for the current item
    list_result_t pending_beats [$];   // beats still owed by the DUT
    int           err_count = 0;
    int           src_idle_pct = 0;
    int           snk_stall_pct = 0;
    bit           draining = 1'b0;     // random mix leans to removes while set
    int           quiet_cycles = 0;

    ordered_value_list #(
        .CAPACITY(LIST_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // receiver: stall at the rate the current phase asks for
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    task automatic report_mismatch(string msg);
        if (err_count < MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic list_result_t make_beat(opcode_t op, logic [31:0] val,
                                               logic has, logic fnd, logic drp,
                                               logic lst);
        list_result_t b;
        b.op = op;
        b.value = val;
        b.has_value = has;
        b.found = fnd;
        b.dropped = drp;
        b.count = 5'(held_values.size());
        b.last = lst;
        return b;
    endfunction

    // list behavior: updates the shadow list and fills step_beats
    function automatic void predict_list_op(opcode_t op, logic [31:0] v);
        int hit;
        step_beats.delete();
        hit = -1;
        case (op)
            OP_APPEND:
            begin
                if (held_values.size() >= LIST_DEPTH)
                    step_beats.push_back(make_beat(op, '0, 1'b0, 1'b0, 1'b1, 1'b1));
                else
                begin
                    held_values.push_back(v);
                    step_beats.push_back(make_beat(op, '0, 1'b0, 1'b0, 1'b0, 1'b1));
                end
            end
            OP_REMOVE, OP_SEARCH:
            begin
                foreach (held_values[i])
                    if (hit < 0 && held_values[i] == v)
                        hit = i;
                if (op == OP_REMOVE && hit >= 0)
                    held_values.delete(hit);
                step_beats.push_back(make_beat(op, '0, 1'b0, hit >= 0, 1'b0, 1'b1));
            end
            default:
            begin
                // dump: one beat per entry, or a single empty beat
                if (held_values.size() == 0)
                    step_beats.push_back(make_beat(op, '0, 1'b0, 1'b0, 1'b0, 1'b1));
                else
                    foreach (held_values[i])
                        step_beats.push_back(make_beat(op, held_values[i], 1'b1, 1'b0,
                                                       1'b0, i == held_values.size() - 1));
            end
        endcase
    endfunction

    // Offer one item, with random idle cycles ahead of it, and book its
    // results once the beat is taken. Valid stays high between back-to-back
    // items; only the idle loop and drain_results lower it.
    task automatic send_item(opcode_t op, logic [31:0] v, logic typed_want,
                             list_result_t want);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tuser  <= {6'b0, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_list_op(op, v);
        if (typed_want)
            pending_beats.push_back(want);
        else
            foreach (step_beats[i])
                pending_beats.push_back(step_beats[i]);
    endtask

    // hold off the sender until every owed beat has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_beats.size() != 0);
    endtask

    // random op mix: grow the list until full, then shrink it back to empty
    function automatic opcode_t pick_op();
        int unsigned r;
        r = $urandom_range(99);
        if (held_values.size() >= LIST_DEPTH)
            draining = 1'b1;
        else if (held_values.size() == 0)
            draining = 1'b0;
        if (draining)
            return (r < 15) ? OP_APPEND : (r < 65) ? OP_REMOVE : (r < 85) ? OP_SEARCH : OP_DUMP;
        return (r < 45) ? OP_APPEND : (r < 65) ? OP_REMOVE : (r < 85) ? OP_SEARCH : OP_DUMP;
    endfunction

    // mostly stored values for remove/search, pool values, some raw noise
    function automatic logic [31:0] pick_value(opcode_t op);
        int unsigned r;
        r = $urandom_range(99);
        if (op != OP_APPEND && held_values.size() != 0 && r < 65)
            return held_values[$urandom_range(held_values.size() - 1)];
        if (r < 80)
            return VALUE_POOL[$urandom_range(7)];
        return $urandom();
    endfunction

    // scoreboard: every accepted output beat against the oldest expectation
    always @(posedge clk)
    begin : check_beats
        list_result_t got;
        list_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.op        = opcode_t'(m_axis_tuser[1:0]);
            got.value     = m_axis_tdata[31:0];
            got.has_value = m_axis_tuser[2];
            got.found     = m_axis_tdata[32];
            got.dropped   = m_axis_tdata[33];
            got.count     = m_axis_tdata[38:34];
            got.last      = m_axis_tlast;
            if (pending_beats.size() == 0)
                report_mismatch($sformatf("unexpected beat op=%0d val=%h cnt=%0d",
                                          got.op, got.value, got.count));
            else
            begin
                want = pending_beats.pop_front();
                if (got !== want)
                    report_mismatch($sformatf(
                        "op %0d/%0d val %h/%h has %b/%b fnd %b/%b drp %b/%b cnt %0d/%0d last %b/%b",
                        got.op, want.op, got.value, want.value, got.has_value,
                        want.has_value, got.found, want.found, got.dropped,
                        want.dropped, got.count, want.count, got.last, want.last));
            end
        end
    end

    // watchdog: too long with no beat moving on either side ends the run
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d beats owed",
                     quiet_cycles, pending_beats.size());
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        opcode_t     op;
        logic [31:0] v;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, no idling
        foreach (DIR_ROWS[r])
            for (int k = 0; k < DIR_ROWS[r].reps; k++)
                send_item(DIR_ROWS[r].op, DIR_ROWS[r].val + k,
                          DIR_ROWS[r].typed_want, DIR_ROWS[r].want);

        // random part; each phase starts from a quiet block
        for (int phase = 0; phase < 4; phase++)
        begin
            drain_results();
            src_idle_pct  = SRC_IDLE_PCT[phase];
            snk_stall_pct = SNK_STALL_PCT[phase];
            repeat (RAND_PER_PHASE)
            begin
                op = pick_op();
                v  = pick_value(op);
                send_item(op, v, 1'b0, '0);
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (err_count == 0 && pending_beats.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
